// ----- src/positional_insert_delete_list_unit_macros.svh -----
// Assertion macros shared by the positional insert/delete list unit.
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PIDL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pidl same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pidl next-cycle check failed");

`endif

// ----- src/pidl_pkg.sv -----
// Package with constants, codes and types of the positional insert/delete list unit.
package pidl_pkg;

   localparam int MAX_LEN    = 64;
   localparam int ELEM_WIDTH = 8;
   localparam int LEN_WIDTH  = 7;
   localparam int SLOT_WIDTH = $clog2(MAX_LEN);

   localparam logic [LEN_WIDTH-1:0] CAPACITY_RESET = LEN_WIDTH'(64);
   localparam logic [LEN_WIDTH-1:0] MAX_LEN_VALUE  = LEN_WIDTH'(MAX_LEN);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_GET    = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   // Command broadcast from the control logic to every cell.
   typedef struct packed {
      logic                  ins;
      logic                  del;
      logic [SLOT_WIDTH-1:0] slot;
      logic [ELEM_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage

// ----- src/pidl_req_if.sv -----
// Request channel interface: operation, position and element to insert.
interface pidl_req_if;
   import pidl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [LEN_WIDTH-1:0]  position;
   logic [ELEM_WIDTH-1:0] new_value;

   modport source (output valid, output func, output position, output new_value, input ready);
   modport sink   (input valid, input func, input position, input new_value, output ready);
endinterface

// ----- src/pidl_rsp_if.sv -----
// Response channel interface: status, element read and list length.
interface pidl_rsp_if;
   import pidl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [ELEM_WIDTH-1:0] read_value;
   logic [LEN_WIDTH-1:0]  length;

   modport source (output valid, output status, output read_value, output length, input ready);
   modport sink   (input valid, input status, input read_value, input length, output ready);
endinterface

// ----- src/pidl_cell.sv -----
// One storage cell of the list: holds an element and shifts with its neighbors.
module pidl_cell (
   input  logic                            clock,
   input  pidl_pkg::cell_cmd_type          cmd,
   input  logic [pidl_pkg::SLOT_WIDTH-1:0] index,
   input  logic [pidl_pkg::ELEM_WIDTH-1:0] left_data,
   input  logic [pidl_pkg::ELEM_WIDTH-1:0] right_data,
   output logic [pidl_pkg::ELEM_WIDTH-1:0] data_out,
   output logic [pidl_pkg::ELEM_WIDTH-1:0] read_data
);
   import pidl_pkg::*;

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;

   // Insert takes the new element at the slot and the left neighbor above it;
   // delete takes the right neighbor from the slot upward.
   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (index == cmd.slot) begin
            data_in = cmd.value;
         end else if (index > cmd.slot) begin
            data_in = left_data;
         end
      end
      if (cmd.del && (index >= cmd.slot)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // The addressed cell drives its element onto the shared read bus.
   assign data_out  = data_ff;
   assign read_data = (index == cmd.slot) ? data_ff : '0;

endmodule

// ----- src/positional_insert_delete_list_unit.sv -----
// Positional insert/delete list unit: an ordered list of up to 64 elements kept in a row of
// shifting cells. Positions count from 1. Insert places an element and moves the later ones up
// (position 0 or beyond length+1 appends), get reads an element, delete removes and returns it,
// clear empties the list; each transaction returns one response with a status and the new
// length. All cells shift in parallel in the cycle the request is accepted, and the response
// sits in an output register, so a new request is taken in each cycle that the response side
// does not stall. The user must write the capacity register (reset 64) through csr_wr_en and
// csr_wr_data only while the unit is idle; the unit itself does not enforce this.
`include "positional_insert_delete_list_unit_macros.svh"

module positional_insert_delete_list_unit (
   input  logic                           clock,
   input  logic                           reset,
   pidl_req_if.sink                       req_chan,
   pidl_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [pidl_pkg::LEN_WIDTH-1:0] csr_wr_data
);
   import pidl_pkg::*;

   logic [LEN_WIDTH-1:0]  capacity_ff;
   logic [LEN_WIDTH-1:0]  length_ff;
   logic [LEN_WIDTH-1:0]  length_in;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [1:0]            rsp_status_in;
   logic [ELEM_WIDTH-1:0] rsp_value_ff;
   logic [ELEM_WIDTH-1:0] rsp_value_in;
   logic [LEN_WIDTH-1:0]  rsp_length_ff;

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  req_reject;
   logic                  rsp_fail;
   logic [LEN_WIDTH-1:0]  limit;
   logic                  is_full;
   logic [LEN_WIDTH-1:0]  pos_m1;
   logic                  append;
   logic [LEN_WIDTH-1:0]  ins_pos;
   logic                  rd_ok;
   logic [ELEM_WIDTH-1:0] rd_data;
   cell_cmd_type          cmd;

   logic [ELEM_WIDTH-1:0] cell_data [MAX_LEN];
   logic [ELEM_WIDTH-1:0] cell_read [MAX_LEN];

   // Handshakes: the response register frees up when it is empty or being taken.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   // Position decoding and range checks.
   assign limit   = (capacity_ff > MAX_LEN_VALUE) ? MAX_LEN_VALUE : capacity_ff;
   assign is_full = length_ff >= limit;
   assign pos_m1  = req_chan.position - LEN_WIDTH'(1);
   assign append  = (req_chan.position == '0) || (pos_m1 > length_ff);
   assign ins_pos = append ? length_ff : pos_m1;
   assign rd_ok   = (req_chan.position != '0) && (req_chan.position <= length_ff);

   // Operation decode: cell command, status and next length.
   always_comb begin
      cmd.ins       = 1'b0;
      cmd.del       = 1'b0;
      cmd.slot      = pos_m1[SLOT_WIDTH-1:0];
      cmd.value     = req_chan.new_value;
      length_in     = length_ff;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      case (func_type'(req_chan.func))
         FUNC_INSERT: begin
            cmd.slot = ins_pos[SLOT_WIDTH-1:0];
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               cmd.ins   = req_fire;
               length_in = length_ff + LEN_WIDTH'(1);
            end
         end
         FUNC_GET: begin
            if (rd_ok) begin
               rsp_value_in = rd_data;
            end else begin
               rsp_status_in = STATUS_RANGE;
            end
         end
         FUNC_DELETE: begin
            if (rd_ok) begin
               cmd.del      = req_fire;
               rsp_value_in = rd_data;
               length_in    = length_ff - LEN_WIDTH'(1);
            end else begin
               rsp_status_in = STATUS_RANGE;
            end
         end
         FUNC_CLEAR: begin
            length_in = '0;
         end
         default: begin
            length_in = length_ff;
         end
      endcase
   end

   // Row of cells, each wired to its left and right neighbor.
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_d;
      logic [ELEM_WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = cmd.value;
      end else begin : g_inner_left
         assign left_d = cell_data[i-1];
      end
      if (i == MAX_LEN - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_inner_right
         assign right_d = cell_data[i+1];
      end
      pidl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .index      (SLOT_WIDTH'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .read_data  (cell_read[i])
      );
   end

   // Read bus: only the addressed cell drives a nonzero value.
   always_comb begin
      rd_data = '0;
      for (int k = 0; k < MAX_LEN; k++) begin
         rd_data = rd_data | cell_read[k];
      end
   end

   // Control registers: capacity, length and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (req_fire) begin
            length_ff    <= length_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_length_ff <= length_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.length     = rsp_length_ff;

   // Flags for the checks below: a rejected request and a failed response.
   assign req_reject = req_fire && (rsp_status_in != STATUS_OK);
   assign rsp_fail   = rsp_valid_ff && (rsp_status_ff != STATUS_OK);

   // The list never grows past the store depth.
   `PIDL_ASSERT_IMPLY(a_len_bound, clock, reset, 1'b1, length_ff <= MAX_LEN_VALUE)
   // A successful insert grows the list by exactly one.
   `PIDL_ASSERT_NEXT(a_ins_grow, clock, reset, cmd.ins, length_ff == $past(length_ff) + LEN_WIDTH'(1))
   // A rejected transaction leaves the length untouched.
   `PIDL_ASSERT_NEXT(a_fail_hold, clock, reset, req_reject, $stable(length_ff))
   // A failed response never carries an element.
   `PIDL_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_fail, rsp_value_ff == '0)

endmodule
